// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL, all clocked on i_clk and idle in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge
`define MCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition implies expression in the same cycle
`define MCB_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Condition implies expression in the next cycle
`define MCB_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/mcb_pkg.sv =====
package mcb_pkg;

    // Fixed payload widths
    localparam int PULSE_W      = 16;
    localparam int FIELD_TICK_W = 24;
    localparam int REPORT_W     = 2;

    // Defaults for the top level parameters
    localparam int DEF_CHANNELS  = 2;
    localparam int DEF_TICK_BITS = 24;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    typedef logic [PULSE_W-1:0]      t_pulse;
    typedef logic [FIELD_TICK_W-1:0] t_field_tick;
    typedef logic [REPORT_W-1:0]     t_report;

endpackage

// ===== src/mcb_ifs.sv =====
// Command / tick item channel
interface mcb_item_if;
    import mcb_pkg::*;

    logic        valid;
    logic        ready;
    logic        operation;
    logic        channel;
    t_pulse      pulse_count;
    t_field_tick on_ticks;
    t_field_tick off_ticks;

    modport source (output valid, operation, channel, pulse_count, on_ticks, off_ticks,
                    input ready);
    modport sink   (input valid, operation, channel, pulse_count, on_ticks, off_ticks,
                    output ready);
endinterface

// Pin status result channel
interface mcb_result_if;
    import mcb_pkg::*;

    logic    valid;
    logic    ready;
    t_report pin_levels;
    t_report channels_busy;

    modport source (output valid, pin_levels, channels_busy, input ready);
    modport sink   (input valid, pin_levels, channels_busy, output ready);
endinterface

// ===== src/multi_channel_blink_scheduler.sv =====
// An item transfer fills the input register; once stage 2 is free the item moves
// on and its result is registered and offered in the result register.
// Throughput: one item per cycle unless results stall; input and result registers
// form a two-stage pipeline, and the per-channel timers update in parallel.
// Reset (i_rst_n low, synchronous): all pins low, all timers disarmed, counts and
// intervals zero, both pipeline stages empty.
`include "assert_macros.svh"

module multi_channel_blink_scheduler #(
    parameter int CHANNELS  = mcb_pkg::DEF_CHANNELS,
    parameter int TICK_BITS = mcb_pkg::DEF_TICK_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mcb_item_if.sink     i_item,
    mcb_result_if.source o_result
);
    import mcb_pkg::*;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Input register
    logic                 r_in_vld;
    logic                 r_op;
    logic                 r_channel;
    t_pulse               r_pulse_count;
    logic [TICK_BITS-1:0] r_on_ticks;
    logic [TICK_BITS-1:0] r_off_ticks;

    // Result register
    logic    r_out_vld;
    t_report r_levels;
    t_report r_busy;

    // Per-channel state
    logic [CHANNELS-1:0]  r_level,   n_level;
    logic [CHANNELS-1:0]  r_armed,   n_armed;
    logic [TICK_BITS-1:0] r_elapsed  [CHANNELS];
    logic [TICK_BITS-1:0] n_elapsed  [CHANNELS];
    logic [TICK_BITS-1:0] r_target   [CHANNELS];
    logic [TICK_BITS-1:0] n_target   [CHANNELS];
    t_pulse               r_pulses   [CHANNELS];
    t_pulse               n_pulses   [CHANNELS];
    logic [TICK_BITS-1:0] r_save_on  [CHANNELS];
    logic [TICK_BITS-1:0] n_save_on  [CHANNELS];
    logic [TICK_BITS-1:0] r_save_off [CHANNELS];
    logic [TICK_BITS-1:0] n_save_off [CHANNELS];

    logic                s2_take;
    logic                fire;
    logic [CHANNELS+1:0] lvl_ext;
    logic [CHANNELS+1:0] busy_ext;

    // Handshake: stage 2 frees when empty or taken, stage 1 when empty or when it moves on
    assign s2_take      = !r_out_vld || o_result.ready;
    assign fire         = r_in_vld && s2_take;
    assign i_item.ready = !r_in_vld || s2_take;

    assign o_result.valid         = r_out_vld;
    assign o_result.pin_levels    = r_levels;
    assign o_result.channels_busy = r_busy;

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_vld <= i_item.valid;
            end
            if (s2_take) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input payload capture, intervals cut to the timer width
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op          <= i_item.operation;
            r_channel     <= i_item.channel;
            r_pulse_count <= i_item.pulse_count;
            r_on_ticks    <= TICK_BITS'(i_item.on_ticks);
            r_off_ticks   <= TICK_BITS'(i_item.off_ticks);
        end
    end

    // Channel update for the item in stage 1
    always_comb begin
        logic [TICK_BITS-1:0] v_inc;
        t_pulse               v_dec;

        v_inc      = '0;
        v_dec      = '0;
        n_level    = r_level;
        n_armed    = r_armed;
        n_elapsed  = r_elapsed;
        n_target   = r_target;
        n_pulses   = r_pulses;
        n_save_on  = r_save_on;
        n_save_off = r_save_off;

        for (int c = 0; c < CHANNELS; c++) begin
            if (fire && r_op == OP_TICK && r_armed[c]) begin
                // saturating timer advance
                v_inc = (r_elapsed[c] == TICK_MAX) ? r_elapsed[c]
                                                   : r_elapsed[c] + TICK_BITS'(1);
                n_elapsed[c] = v_inc;
                if (v_inc >= r_target[c]) begin
                    if (r_level[c]) begin
                        // end of an on pulse
                        n_level[c] = 1'b0;
                        v_dec = (r_pulses[c] != '0) ? r_pulses[c] - PULSE_W'(1) : '0;
                        n_pulses[c] = v_dec;
                        if (v_dec != '0) begin
                            n_armed[c]   = 1'b1;
                            n_elapsed[c] = '0;
                            n_target[c]  = r_save_off[c];
                        end else begin
                            n_armed[c] = 1'b0;
                        end
                    end else begin
                        // end of an off gap
                        n_level[c]   = 1'b1;
                        n_armed[c]   = 1'b1;
                        n_elapsed[c] = '0;
                        n_target[c]  = r_save_on[c];
                    end
                end
            end else if (fire && r_op == OP_CMD && int'(r_channel) == c) begin
                if (r_pulse_count == '0) begin
                    // stop
                    n_level[c]  = 1'b0;
                    n_pulses[c] = '0;
                    n_armed[c]  = 1'b0;
                end else begin
                    // start
                    n_level[c]    = 1'b1;
                    n_pulses[c]   = r_pulse_count;
                    n_save_on[c]  = r_on_ticks;
                    n_save_off[c] = r_off_ticks;
                    n_armed[c]    = 1'b1;
                    n_elapsed[c]  = '0;
                    n_target[c]   = r_on_ticks;
                end
            end
        end
    end

    // Channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_armed <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_elapsed[c]  <= '0;
                r_target[c]   <= '0;
                r_pulses[c]   <= '0;
                r_save_on[c]  <= '0;
                r_save_off[c] <= '0;
            end
        end else begin
            r_level    <= n_level;
            r_armed    <= n_armed;
            r_elapsed  <= n_elapsed;
            r_target   <= n_target;
            r_pulses   <= n_pulses;
            r_save_on  <= n_save_on;
            r_save_off <= n_save_off;
        end
    end

    // Only the first two channels are reported
    assign lvl_ext  = {2'b00, n_level};
    assign busy_ext = {2'b00, n_armed};

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_levels <= lvl_ext[REPORT_W-1:0];
            r_busy   <= busy_ext[REPORT_W-1:0];
        end
    end

    // Checks
    `MCB_ASSERT_NXT(a_fire_to_result, fire, r_out_vld, "item left stage 1 but no result")
    `MCB_ASSERT_IMP(a_stall_cause, !i_item.ready, r_in_vld && r_out_vld && !o_result.ready, "input stalled without a full pipe")
    `MCB_ASSERT_IMP(a_armed_has_pulses, r_armed[0], r_pulses[0] != '0, "armed channel with no pulses left")
    `MCB_ASSERT_NXT(a_stop_clears, fire && r_op == OP_CMD && r_channel == 1'b0 && r_pulse_count == '0, !r_level[0] && !r_armed[0] && !r_levels[0] && !r_busy[0], "stop command left channel active")

endmodule

// ===== tb/blink_status_checker.sv =====
`timescale 1ns / 1ps

// Watches the item and result channels, predicts the pin status for every
// accepted item and compares it with the result stream in order.
module blink_status_checker #(
    parameter int CHANNELS  = mcb_pkg::DEF_CHANNELS,
    parameter int TICK_BITS = mcb_pkg::DEF_TICK_BITS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mcb_item_if    item_mon,
    mcb_result_if  result_mon,
    output int     o_fail_count,
    output int     o_pending
);
    import mcb_pkg::*;

    typedef logic [TICK_BITS-1:0] t_tick;

    // Per-channel blink state
    typedef struct {
        logic   level;
        logic   armed;
        t_tick  elapsed;
        t_tick  target;
        t_pulse pulses;
        t_tick  on_len;
        t_tick  off_len;
    } t_chan_state;

    typedef struct packed {
        t_report pins;
        t_report busy;
    } t_pin_status;

    t_chan_state chan_st [CHANNELS];
    t_pin_status expected_status_q [$];
    t_pin_status exp_status;
    int          mismatches;

    // One-shot timer restarts from zero
    function automatic void arm_interval(int c, t_tick len);
        chan_st[c].armed   = 1'b1;
        chan_st[c].elapsed = '0;
        chan_st[c].target  = len;
    endfunction

    // Advance the model by one item and return the pins it leaves behind
    function automatic t_pin_status predict_pin_status(logic op, logic ch, t_pulse cnt,
                                                       t_field_tick on_t, t_field_tick off_t);
        t_pin_status st;
        int          c;
        if (op == OP_TICK) begin
            for (c = 0; c < CHANNELS; c++) begin
                if (chan_st[c].armed) begin
                    if (chan_st[c].elapsed != '1)
                        chan_st[c].elapsed = chan_st[c].elapsed + 1'b1;
                    if (chan_st[c].elapsed >= chan_st[c].target) begin
                        if (chan_st[c].level) begin
                            chan_st[c].level = 1'b0;
                            if (chan_st[c].pulses != '0)
                                chan_st[c].pulses = chan_st[c].pulses - 1'b1;
                            if (chan_st[c].pulses != '0)
                                arm_interval(c, chan_st[c].off_len);
                            else
                                chan_st[c].armed = 1'b0;
                        end else begin
                            chan_st[c].level = 1'b1;
                            arm_interval(c, chan_st[c].on_len);
                        end
                    end
                end
            end
        end else if (int'(ch) < CHANNELS) begin
            c = int'(ch);
            if (cnt == '0) begin
                // stop: pin low, count cleared, intervals kept
                chan_st[c].level  = 1'b0;
                chan_st[c].pulses = '0;
                chan_st[c].armed  = 1'b0;
            end else begin
                chan_st[c].level   = 1'b1;
                chan_st[c].pulses  = cnt;
                chan_st[c].on_len  = TICK_BITS'(on_t);
                chan_st[c].off_len = TICK_BITS'(off_t);
                arm_interval(c, chan_st[c].on_len);
            end
        end
        st = '0;
        for (c = 0; c < CHANNELS && c < REPORT_W; c++) begin
            st.pins[c] = chan_st[c].level;
            st.busy[c] = chan_st[c].armed;
        end
        return st;
    endfunction

    // Compare result transfers first, then queue the prediction for a new item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                chan_st[c] = '{1'b0, 1'b0, '0, '0, '0, '0, '0};
            end
            expected_status_q.delete();
            mismatches   = 0;
            o_fail_count = 0;
        end else begin
            if (result_mon.valid && result_mon.ready) begin
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: pins %b busy %b", $time,
                                 result_mon.pin_levels, result_mon.channels_busy);
                end else begin
                    exp_status = expected_status_q.pop_front();
                    if (result_mon.pin_levels !== exp_status.pins ||
                        result_mon.channels_busy !== exp_status.busy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: pins exp %b got %b, busy exp %b got %b",
                                     $time, exp_status.pins, result_mon.pin_levels,
                                     exp_status.busy, result_mon.channels_busy);
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
                expected_status_q.push_back(predict_pin_status(item_mon.operation,
                    item_mon.channel, item_mon.pulse_count, item_mon.on_ticks,
                    item_mon.off_ticks));
            o_fail_count = mismatches;
        end
        o_pending = expected_status_q.size();
    end

endmodule

// ===== tb/tb_multi_channel_blink_scheduler.sv =====
`timescale 1ns / 1ps

module tb_multi_channel_blink_scheduler;
    import mcb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   hold_left;

    mcb_item_if   item_if ();
    mcb_result_if result_if ();

    multi_channel_blink_scheduler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    blink_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_mon     (item_if),
        .result_mon   (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run guard
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
                hold_left--;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic offer_item(logic op, logic ch, t_pulse cnt, t_field_tick on_t,
                              t_field_tick off_t);
        while ($urandom_range(0, 99) < idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.operation   <= op;
        item_if.channel     <= ch;
        item_if.pulse_count <= cnt;
        item_if.on_ticks    <= on_t;
        item_if.off_ticks   <= off_t;
        do
            @(posedge i_clk);
        while (!(item_if.valid && item_if.ready));
    endtask

    // Mostly ticks with short intervals so pulses run to completion
    task automatic offer_random_item();
        int          pick;
        t_pulse      cnt;
        t_field_tick on_t;
        t_field_tick off_t;
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
            offer_item(OP_TICK, 1'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 12)      cnt = '0;
            else if (pick < 17) cnt = 16'($urandom);
            else if (pick < 20) cnt = '1;
            else                cnt = 16'($urandom_range(1, 4));
            pick = $urandom_range(0, 99);
            if (pick < 88)      on_t = 24'($urandom_range(0, 6));
            else if (pick < 96) on_t = 24'($urandom);
            else                on_t = '1;
            pick = $urandom_range(0, 99);
            if (pick < 88)      off_t = 24'($urandom_range(0, 6));
            else if (pick < 96) off_t = 24'($urandom);
            else                off_t = '1;
            offer_item(OP_CMD, 1'($urandom), cnt, on_t, off_t);
        end
    endtask

    // Sender goes quiet until every expected result has been seen
    task automatic drain_results();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // Stimulus
    initial begin
        int phase_idle  [4] = '{0, 81, 0, 7};
        int phase_stall [4] = '{0, 0, 81, 7};
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        i_rst_n             <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.operation   <= OP_TICK;
        item_if.channel     <= 1'b0;
        item_if.pulse_count <= '0;
        item_if.on_ticks    <= '0;
        item_if.off_ticks   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick with junk fields, stop while idle
        offer_item(OP_TICK, 1'b1, '1, '1, '1);
        offer_item(OP_CMD, 1'b0, '0, '1, '1);
        // zero intervals: expiry on the very next tick
        offer_item(OP_CMD, 1'b0, 16'd1, '0, '0);
        offer_item(OP_TICK, 1'b0, '0, '0, '0);
        offer_item(OP_TICK, 1'b0, '0, '0, '0);
        // two pulses on channel 1, on one tick, off zero
        offer_item(OP_CMD, 1'b1, 16'd2, 24'd1, '0);
        repeat (5) offer_item(OP_TICK, 1'b1, '1, '0, '1);
        // widest intervals and count, then stop while high
        offer_item(OP_CMD, 1'b0, '1, '1, '1);
        offer_item(OP_TICK, 1'b0, '0, '0, '0);
        offer_item(OP_CMD, 1'b1, 16'd3, 24'd2, 24'd2);
        offer_item(OP_CMD, 1'b0, '0, '0, '0);
        repeat (3) offer_item(OP_TICK, 1'b0, '0, '0, '0);
        // stop channel 1 while low in its off interval
        offer_item(OP_CMD, 1'b1, '0, 24'h5A5A5A, 24'hA5A5A5);
        // restart over a running channel
        offer_item(OP_CMD, 1'b0, 16'd1, 24'd3, 24'd1);
        offer_item(OP_CMD, 1'b0, 16'h8000, 24'h800000, 24'd1);
        offer_item(OP_TICK, 1'b0, '0, '0, '0);

        // Long receiver hold-off with the sender pushing flat out
        hold_left = 80;
        repeat (40) offer_random_item();
        drain_results();

        // Random phases with varying idle and stall rates
        for (int p = 0; p < 4; p++) begin
            drain_results();
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (350) offer_random_item();
        end

        // Wind down
        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
